>>> hdl/spe_pkg.sv
// Shared types, widths and codes for the stuck particle eliminator.
`default_nettype none

package spe_pkg;

	// Default number of table entries.
	localparam int SPE_TABLE_DEPTH = 4096;

	// Field widths.
	localparam int KEY_W   = 12;
	localparam int FACE_W  = 24;
	localparam int POS_W   = 32;
	localparam int CNT_W   = 16;
	localparam int DIST_W  = 31;
	localparam int TOTAL_W = 13;
	localparam int CMD_W   = 2;
	localparam int REG_W   = 2;
	localparam int RSN_W   = 2;
	localparam int STEP_W  = 4;
	localparam int SQ_W    = 2 * DIST_W;
	localparam int ACC_W   = 64;

	// Commands.
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
	localparam logic [CMD_W-1:0] CMD_HIT   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_MOVE  = 2'd2;

	// Configuration register indexes.
	localparam logic [REG_W-1:0] REG_MAX_HITS   = 2'd0;
	localparam logic [REG_W-1:0] REG_MIN_DIST   = 2'd1;
	localparam logic [REG_W-1:0] REG_INT_FACES  = 2'd2;

	// Elimination reasons.
	localparam logic [RSN_W-1:0] REASON_NONE  = 2'd0;
	localparam logic [RSN_W-1:0] REASON_CLOSE = 2'd1;
	localparam logic [RSN_W-1:0] REASON_FACE  = 2'd2;

	// Saturation limits.
	localparam logic [CNT_W-1:0]   CNT_MAX   = '1;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

	// Distance sequence: step 0 squares the limit, steps 1 to 3 square one axis each,
	// and the last product is accumulated at STEP_DIST_DONE.
	localparam logic [STEP_W-1:0] STEP_LIM        = 4'd0;
	localparam logic [STEP_W-1:0] STEP_AXIS_X     = 4'd1;
	localparam logic [STEP_W-1:0] STEP_AXIS_Y     = 4'd2;
	localparam logic [STEP_W-1:0] STEP_LAST_ISSUE = 4'd3;
	localparam logic [STEP_W-1:0] STEP_DIST_DONE  = 4'd5;

	// One table entry.
	typedef struct packed {
		logic                    present;
		logic                    elim;
		logic [CNT_W-1:0]        hit_count;
		logic                    face_valid;
		logic [FACE_W-1:0]       face;
		logic                    pos_valid;
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic signed [POS_W-1:0] pos_z;
	} entry_t;

	// Operation issued to the distance unit.
	typedef struct packed {
		logic issue;
		logic lim;
	} dist_op_t;

endpackage

`default_nettype wire

>>> hdl/spe_table.sv
// Particle table memory: one shared address, registered read data.
`default_nettype none

module spe_table
	import spe_pkg::*;
#(
	parameter int DEPTH = SPE_TABLE_DEPTH,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] addr,
	input  wire entry_t            wr_data,
	output entry_t                 rd_data
);

	entry_t mem_q [DEPTH];
	entry_t rd_data_q;

	// Single-port array with a read register.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

>>> hdl/spe_dist.sv
// Shared square-and-accumulate unit for the minimum distance check.
`default_nettype none

module spe_dist
	import spe_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire dist_op_t                op,
	input  wire logic [DIST_W-1:0]       min_distance,
	input  wire logic signed [POS_W-1:0] last_pos,
	input  wire logic signed [POS_W-1:0] new_pos,
	output logic                         close
);

	logic signed [POS_W:0] diff;
	logic [POS_W:0]        mag;
	logic                  v_s1, lim_s1, far_s1;
	logic [DIST_W-1:0]     opa_s1;
	logic                  v_s2, lim_s2, far_s2;
	logic [SQ_W-1:0]       prod_s2;
	logic [SQ_W-1:0]       lim_q;
	logic [ACC_W-1:0]      acc_q;
	logic                  far_q;

	// Magnitude of the coordinate difference; at or above 2^31 it can never be close.
	assign diff = {last_pos[POS_W-1], last_pos} - {new_pos[POS_W-1], new_pos};
	assign mag  = diff[POS_W] ? $unsigned(-diff) : $unsigned(diff);

	// Valid and kind bits travelling with the operands.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			lim_s1 <= 1'b0;
			v_s2   <= 1'b0;
			lim_s2 <= 1'b0;
		end else begin
			v_s1   <= op.issue;
			lim_s1 <= op.lim;
			v_s2   <= v_s1;
			lim_s2 <= lim_s1;
		end
	end

	// Operand select, squaring and accumulation, one register between each.
	always_ff @(posedge clk) begin
		opa_s1  <= op.lim ? min_distance : mag[DIST_W-1:0];
		far_s1  <= !op.lim && (mag[POS_W] || mag[POS_W-1]);
		prod_s2 <= opa_s1 * opa_s1;
		far_s2  <= far_s1;
		if (v_s2) begin
			if (lim_s2) begin
				lim_q <= prod_s2;
				acc_q <= '0;
				far_q <= 1'b0;
			end else begin
				acc_q <= acc_q + ACC_W'(prod_s2);
				far_q <= far_q || far_s2;
			end
		end
	end

	// Squared distance strictly below the squared limit.
	assign close = !far_q && (acc_q < ACC_W'(lim_q));

endmodule

`default_nettype wire

>>> hdl/stuck_particle_eliminator.sv
// Top level: sequencer, configuration, result register and assertions.
// A face hit on a known boundary entry runs the distance sequence and a table update, other hits
// and moves read and evaluate the entry, an unused command goes straight to the result, a clear
// sweeps the table, and a depth below 4096 adds key reduction. A waiting result holds the block
// until taken. One request at a time; the next is taken in the cycle after the result is loaded.
// Reset (arst_n, asynchronous, active low) starts a clearing pass over the table, in_ready low.
`default_nettype none

module stuck_particle_eliminator
	import spe_pkg::*;
#(
	parameter int TABLE_DEPTH = SPE_TABLE_DEPTH
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_write,
	input  wire logic [REG_W-1:0]        cfg_index,
	input  wire logic [DIST_W-1:0]       cfg_data,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic [CMD_W-1:0]        command,
	input  wire logic [KEY_W-1:0]        particle_key,
	input  wire logic [FACE_W-1:0]       face_index,
	input  wire logic signed [POS_W-1:0] pos_x,
	input  wire logic signed [POS_W-1:0] pos_y,
	input  wire logic signed [POS_W-1:0] pos_z,
	input  wire logic                    keep_in,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic                         keep_out,
	output logic                         newly_eliminated,
	output logic [RSN_W-1:0]             reason,
	output logic [TOTAL_W-1:0]           eliminated_count
);

	localparam int ADDR_W = $clog2(TABLE_DEPTH);
	localparam bit NEED_RED = TABLE_DEPTH < (1 << KEY_W);
	localparam int RED_MW = KEY_W + 2;
	localparam int RED_PW = KEY_W + RED_MW;
	localparam int RED_BW = 2 * KEY_W;
	localparam int RED_S  = KEY_W + ADDR_W;
	localparam logic [RED_MW-1:0] RED_M =
		RED_MW'(((64'd1 << RED_S) + 64'(TABLE_DEPTH) - 64'd1) / 64'(TABLE_DEPTH));

	typedef enum logic [7:0] {
		ST_CLR  = 8'b0000_0001,
		ST_IDLE = 8'b0000_0010,
		ST_KEY  = 8'b0000_0100,
		ST_READ = 8'b0000_1000,
		ST_EVAL = 8'b0001_0000,
		ST_DIST = 8'b0010_0000,
		ST_UPD  = 8'b0100_0000,
		ST_DONE = 8'b1000_0000
	} state_t;

	state_t                  state_q;
	logic [STEP_W-1:0]       step_q;
	logic [ADDR_W-1:0]       clr_q;
	logic                    sweep_cmd_q;

	logic [CNT_W-1:0]        max_hits_q;
	logic [DIST_W-1:0]       min_dist_q;
	logic [FACE_W-1:0]       int_faces_q;

	logic [CMD_W-1:0]        cmd_q;
	logic [KEY_W-1:0]        key_q;
	logic [KEY_W-1:0]        quo_q;
	logic [FACE_W-1:0]       face_q;
	logic signed [POS_W-1:0] px_q, py_q, pz_q;
	logic                    keep_q;

	logic                    res_keep_q, res_newly_q;
	logic [RSN_W-1:0]        res_reason_q;
	logic [TOTAL_W-1:0]      elim_total_q;

	logic                    out_valid_q, keep_out_q, newly_q;
	logic [RSN_W-1:0]        reason_q;
	logic [TOTAL_W-1:0]      count_q;

	logic                    mem_we, mem_re;
	logic [ADDR_W-1:0]       mem_addr;
	entry_t                  mem_wdata, rd_entry;

	dist_op_t                dist_op;
	logic signed [POS_W-1:0] dist_last, dist_new;
	logic                    dist_close;

	logic [RED_PW-1:0]       red_prod;
	logic [KEY_W-1:0]        red_quo;
	logic [KEY_W-1:0]        red_back;
	logic                    is_internal;
	logic                    clr_last;

	entry_t                  upd_entry;
	logic                    upd_keep, upd_newly;
	logic [RSN_W-1:0]        upd_reason;
	logic [CNT_W-1:0]        cnt_next;

	// Table memory and the shared distance unit.
	spe_table #(
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk    (clk),
		.wr_en  (mem_we),
		.rd_en  (mem_re),
		.addr   (mem_addr),
		.wr_data(mem_wdata),
		.rd_data(rd_entry)
	);

	spe_dist u_dist (
		.clk         (clk),
		.arst_n      (arst_n),
		.op          (dist_op),
		.min_distance(min_dist_q),
		.last_pos    (dist_last),
		.new_pos     (dist_new),
		.close       (dist_close)
	);

	// Key reduction: quotient by reciprocal multiplication, then the remainder by one subtract.
	assign red_prod = RED_PW'(key_q) * RED_PW'(RED_M);
	assign red_quo  = KEY_W'(red_prod >> RED_S);
	assign red_back = KEY_W'(RED_BW'(quo_q) * RED_BW'(TABLE_DEPTH));

	assign is_internal = face_q < int_faces_q;
	assign clr_last    = clr_q == ADDR_W'(TABLE_DEPTH - 1);
	assign mem_addr    = (state_q == ST_CLR) ? clr_q : ADDR_W'(key_q);
	assign mem_re      = state_q == ST_READ;

	// Distance unit operands: the limit first, then one axis a step.
	always_comb begin
		dist_op.issue = (state_q == ST_DIST) && (step_q <= STEP_LAST_ISSUE);
		dist_op.lim   = step_q == STEP_LIM;
		case (step_q)
			STEP_AXIS_X: begin
				dist_last = rd_entry.pos_x;
				dist_new  = px_q;
			end
			STEP_AXIS_Y: begin
				dist_last = rd_entry.pos_y;
				dist_new  = py_q;
			end
			default: begin
				dist_last = rd_entry.pos_z;
				dist_new  = pz_q;
			end
		endcase
	end

	// Boundary hit on a known entry: distance check, then same-face count.
	always_comb begin
		upd_entry  = rd_entry;
		upd_keep   = keep_q;
		upd_newly  = 1'b0;
		upd_reason = REASON_NONE;
		cnt_next   = (rd_entry.hit_count == CNT_MAX) ? CNT_MAX
			: rd_entry.hit_count + CNT_W'(1);
		if ((min_dist_q != '0) && rd_entry.pos_valid && dist_close && keep_q) begin
			upd_keep   = 1'b0;
			upd_reason = REASON_CLOSE;
			if (!rd_entry.elim) begin
				upd_entry.elim = 1'b1;
				upd_newly      = 1'b1;
			end
		end
		if (max_hits_q > CNT_W'(1)) begin
			if (rd_entry.face_valid && (rd_entry.face == face_q)) begin
				upd_entry.hit_count = cnt_next;
				if ((cnt_next > max_hits_q) && upd_keep) begin
					upd_keep   = 1'b0;
					upd_reason = REASON_FACE;
					if (!upd_entry.elim) begin
						upd_entry.elim = 1'b1;
						upd_newly      = 1'b1;
					end
				end
			end else begin
				upd_entry.hit_count  = CNT_W'(1);
				upd_entry.face_valid = 1'b1;
				upd_entry.face       = face_q;
			end
		end
		upd_entry.pos_x     = px_q;
		upd_entry.pos_y     = py_q;
		upd_entry.pos_z     = pz_q;
		upd_entry.pos_valid = 1'b1;
	end

	// Table writes: clearing pass, first hit, internal face reset, boundary update.
	always_comb begin
		mem_we    = 1'b0;
		mem_wdata = rd_entry;
		unique case (state_q)
			ST_CLR: begin
				mem_we    = 1'b1;
				mem_wdata = '0;
			end
			ST_EVAL: begin
				if (cmd_q == CMD_HIT) begin
					if (is_internal) begin
						if (rd_entry.present) begin
							mem_we               = 1'b1;
							mem_wdata.hit_count  = '0;
							mem_wdata.face_valid = 1'b0;
							mem_wdata.face       = '0;
							mem_wdata.pos_valid  = 1'b0;
						end
					end else if (!rd_entry.present) begin
						mem_we               = 1'b1;
						mem_wdata.present    = 1'b1;
						mem_wdata.hit_count  = CNT_W'(1);
						mem_wdata.face_valid = 1'b1;
						mem_wdata.face       = face_q;
						mem_wdata.pos_x      = px_q;
						mem_wdata.pos_y      = py_q;
						mem_wdata.pos_z      = pz_q;
						mem_wdata.pos_valid  = 1'b1;
					end
				end
			end
			ST_UPD: begin
				mem_we    = 1'b1;
				mem_wdata = upd_entry;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_hits_q  <= '0;
			min_dist_q  <= '0;
			int_faces_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_MAX_HITS:  max_hits_q  <= cfg_data[CNT_W-1:0];
				REG_MIN_DIST:  min_dist_q  <= cfg_data;
				REG_INT_FACES: int_faces_q <= cfg_data[FACE_W-1:0];
				default: ;
			endcase
		end
	end

	// Request capture.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q  <= command;
			face_q <= face_index;
			px_q   <= pos_x;
			py_q   <= pos_y;
			pz_q   <= pos_z;
			keep_q <= keep_in;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLR;
			step_q       <= '0;
			clr_q        <= '0;
			sweep_cmd_q  <= 1'b0;
			key_q        <= '0;
			quo_q        <= '0;
			res_keep_q   <= 1'b0;
			res_newly_q  <= 1'b0;
			res_reason_q <= REASON_NONE;
			elim_total_q <= '0;
			out_valid_q  <= 1'b0;
			keep_out_q   <= 1'b0;
			newly_q      <= 1'b0;
			reason_q     <= REASON_NONE;
			count_q      <= '0;
		end else begin
			// A result taken while the next one is being loaded is replaced in ST_DONE.
			if (out_valid_q && out_ready && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLR: begin
					if (clr_last) begin
						clr_q   <= '0;
						state_q <= sweep_cmd_q ? ST_DONE : ST_IDLE;
					end else begin
						clr_q <= clr_q + ADDR_W'(1);
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						key_q        <= particle_key;
						res_keep_q   <= keep_in;
						res_newly_q  <= 1'b0;
						res_reason_q <= REASON_NONE;
						step_q       <= '0;
						if (command == CMD_CLEAR) begin
							sweep_cmd_q  <= 1'b1;
							elim_total_q <= '0;
							state_q      <= ST_CLR;
						end else if (command == CMD_HIT || command == CMD_MOVE) begin
							state_q <= NEED_RED ? ST_KEY : ST_READ;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_KEY: begin
					if (step_q == '0) begin
						quo_q  <= red_quo;
						step_q <= STEP_W'(1);
					end else begin
						key_q   <= key_q - red_back;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					step_q  <= STEP_LIM;
					state_q <= ST_DONE;
					if (cmd_q == CMD_MOVE) begin
						res_keep_q <= keep_q && !rd_entry.elim;
					end else if (!is_internal && rd_entry.present) begin
						state_q <= ST_DIST;
					end
				end
				ST_DIST: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_DIST_DONE) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					res_keep_q   <= upd_keep;
					res_newly_q  <= upd_newly;
					res_reason_q <= upd_reason;
					if (upd_newly && (elim_total_q != TOTAL_MAX)) begin
						elim_total_q <= elim_total_q + TOTAL_W'(1);
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						keep_out_q  <= res_keep_q;
						newly_q     <= res_newly_q;
						reason_q    <= res_reason_q;
						count_q     <= elim_total_q;
						sweep_cmd_q <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready         = state_q == ST_IDLE;
	assign out_valid        = out_valid_q;
	assign keep_out         = keep_out_q;
	assign newly_eliminated = newly_q;
	assign reason           = reason_q;
	assign eliminated_count = count_q;

`ifndef SYNTHESIS
	// An accepted request keeps the block busy in the following cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("request accepted while still busy");

	// A newly eliminated particle is always dropped, with a reason.
	a_newly_has_reason: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && newly_eliminated) |-> (!keep_out && reason != REASON_NONE))
		else $error("newly eliminated result without drop or reason");

	// The clearing pass writes an empty entry on every cycle.
	a_clear_writes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLR) |-> (mem_we && !mem_wdata.present && !mem_wdata.elim))
		else $error("clearing pass did not write an empty entry");
`endif

endmodule

`default_nettype wire

>>> tb/stuck_particle_eliminator_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the stuck particle eliminator: directed table, then random requests.

module stuck_particle_eliminator_tb;
	import spe_pkg::*;

	localparam int DEPTH          = SPE_TABLE_DEPTH;
	localparam int CYCLE_LIMIT    = 1000000;
	localparam int PHASES         = 6;
	localparam int PHASE_REQUESTS = 314;
	localparam int HOT_KEYS       = 24;
	localparam int SETTLE_CYCLES  = 32;
	localparam int REPORT_LIMIT   = 10;

	// One request as presented on the input channel.
	typedef struct packed {
		logic [CMD_W-1:0]        cmd;
		logic [KEY_W-1:0]        key;
		logic [FACE_W-1:0]       face;
		logic signed [POS_W-1:0] px;
		logic signed [POS_W-1:0] py;
		logic signed [POS_W-1:0] pz;
		logic                    keep;
	} request_t;

	// One verdict as returned on the output channel.
	typedef struct packed {
		logic               keep;
		logic               newly;
		logic [RSN_W-1:0]   why;
		logic [TOTAL_W-1:0] total;
	} verdict_t;

	// One row of the directed table; typed rows carry their verdict, the rest use the predictor.
	typedef struct packed {
		request_t req;
		logic     typed;
		verdict_t want;
	} stim_row_t;

	logic                    clk;
	logic                    arst_n           = 1'b0;
	logic                    cfg_write        = 1'b0;
	logic [REG_W-1:0]        cfg_index        = REG_MAX_HITS;
	logic [DIST_W-1:0]       cfg_data         = '0;
	logic                    in_valid         = 1'b0;
	logic                    in_ready;
	logic [CMD_W-1:0]        command          = CMD_MOVE;
	logic [KEY_W-1:0]        particle_key     = '0;
	logic [FACE_W-1:0]       face_index       = '0;
	logic signed [POS_W-1:0] pos_x            = '0;
	logic signed [POS_W-1:0] pos_y            = '0;
	logic signed [POS_W-1:0] pos_z            = '0;
	logic                    keep_in          = 1'b0;
	logic                    out_valid;
	logic                    out_ready        = 1'b0;
	logic                    keep_out;
	logic                    newly_eliminated;
	logic [RSN_W-1:0]        reason;
	logic [TOTAL_W-1:0]      eliminated_count;

	stuck_particle_eliminator dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_write        (cfg_write),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.command          (command),
		.particle_key     (particle_key),
		.face_index       (face_index),
		.pos_x            (pos_x),
		.pos_y            (pos_y),
		.pos_z            (pos_z),
		.keep_in          (keep_in),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.keep_out         (keep_out),
		.newly_eliminated (newly_eliminated),
		.reason           (reason),
		.eliminated_count (eliminated_count)
	);

	// Shadow copy of the configuration and of the particle table.
	logic [CNT_W-1:0]        max_hits_shadow   = '0;
	logic [DIST_W-1:0]       min_dist_shadow   = '0;
	logic [FACE_W-1:0]       int_faces_shadow  = '0;
	bit                      known     [DEPTH];
	bit                      dropped   [DEPTH];
	logic [CNT_W-1:0]        run_len   [DEPTH];
	bit                      face_ok   [DEPTH];
	logic [FACE_W-1:0]       prev_face [DEPTH];
	bit                      pos_ok    [DEPTH];
	bit signed [POS_W-1:0]   prev_x    [DEPTH];
	bit signed [POS_W-1:0]   prev_y    [DEPTH];
	bit signed [POS_W-1:0]   prev_z    [DEPTH];
	logic [TOTAL_W-1:0]      dropped_total = '0;

	verdict_t          verdicts_due[$];
	stim_row_t         directed_rows[$];
	logic [KEY_W-1:0]  hot_key[HOT_KEYS];
	int                mismatches    = 0;
	int                cycles        = 0;
	int                send_idle_pct = 0;
	int                recv_idle_pct = 0;

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// True when the particle has moved less than the minimum distance since its last hit.
	function automatic bit moved_too_little(int k, request_t r);
		logic [63:0] lim;
		logic [63:0] sum;
		logic [63:0] mag;
		longint      d[3];
		lim  = 64'(min_dist_shadow) * 64'(min_dist_shadow);
		d[0] = longint'(prev_x[k]) - longint'($signed(r.px));
		d[1] = longint'(prev_y[k]) - longint'($signed(r.py));
		d[2] = longint'(prev_z[k]) - longint'($signed(r.pz));
		sum  = '0;
		for (int i = 0; i < 3; i++) begin
			mag = (d[i] < 0) ? 64'(-d[i]) : 64'(d[i]);
			if (mag >= 64'h8000_0000)
				return 1'b0;
			sum += mag * mag;
		end
		return sum < lim;
	endfunction

	// Adds a particle to the eliminated set; returns 1 if it was not there yet.
	function automatic bit mark_dropped(int k);
		if (dropped[k])
			return 1'b0;
		dropped[k] = 1'b1;
		if (dropped_total != TOTAL_MAX)
			dropped_total++;
		return 1'b1;
	endfunction

	// Works out the verdict for one request and advances the shadow table.
	function automatic verdict_t predict_verdict(request_t r);
		verdict_t v;
		int       k;
		k       = int'(r.key);
		v.keep  = r.keep;
		v.newly = 1'b0;
		v.why   = REASON_NONE;
		case (r.cmd)
			CMD_CLEAR: begin
				for (int i = 0; i < DEPTH; i++) begin
					known[i]   = 1'b0;
					dropped[i] = 1'b0;
				end
				dropped_total = '0;
			end
			CMD_MOVE: begin
				if (dropped[k])
					v.keep = 1'b0;
			end
			CMD_HIT: begin
				if (r.face < int_faces_shadow) begin
					// An internal face forgets the history of a known particle.
					if (known[k]) begin
						run_len[k] = '0;
						face_ok[k] = 1'b0;
						pos_ok[k]  = 1'b0;
					end
				end else if (known[k]) begin
					// Distance check first, then the same-face run.
					if (min_dist_shadow != 0 && pos_ok[k] && v.keep && moved_too_little(k, r)) begin
						v.keep = 1'b0;
						v.why  = REASON_CLOSE;
						if (mark_dropped(k))
							v.newly = 1'b1;
					end
					if (max_hits_shadow > 1) begin
						if (face_ok[k] && prev_face[k] == r.face) begin
							if (run_len[k] != CNT_MAX)
								run_len[k]++;
							if (run_len[k] > max_hits_shadow && v.keep) begin
								v.keep = 1'b0;
								v.why  = REASON_FACE;
								if (mark_dropped(k))
									v.newly = 1'b1;
							end
						end else begin
							run_len[k]   = 1;
							face_ok[k]   = 1'b1;
							prev_face[k] = r.face;
						end
					end
					prev_x[k] = r.px;
					prev_y[k] = r.py;
					prev_z[k] = r.pz;
					pos_ok[k] = 1'b1;
				end else begin
					// First boundary hit only records the particle.
					known[k]     = 1'b1;
					run_len[k]   = 1;
					face_ok[k]   = 1'b1;
					prev_face[k] = r.face;
					prev_x[k]    = r.px;
					prev_y[k]    = r.py;
					prev_z[k]    = r.pz;
					pos_ok[k]    = 1'b1;
				end
			end
			default: ;
		endcase
		v.total = dropped_total;
		return v;
	endfunction

	// Builds one row of the directed table.
	function automatic stim_row_t stim_row(logic [CMD_W-1:0] c, int k, int f, int x, int y, int z,
			bit kp, bit typed, bit ek, bit en, logic [RSN_W-1:0] er, int ec);
		stim_row_t s;
		s.req   = '{c, KEY_W'(k), FACE_W'(f), POS_W'(x), POS_W'(y), POS_W'(z), kp};
		s.typed = typed;
		s.want  = '{ek, en, er, TOTAL_W'(ec)};
		return s;
	endfunction

	// Random offset in the range -span to span.
	function automatic longint jitter(logic [63:0] span);
		return longint'({$urandom, $urandom} % (2 * span + 1)) - longint'(span);
	endfunction

	// Random request, biased towards repeated keys, faces and nearby positions.
	function automatic request_t random_request();
		request_t    r;
		int          k;
		int          pick;
		logic [63:0] span;
		pick  = $urandom_range(999);
		r.cmd = (pick < 5) ? CMD_CLEAR : ((pick < 700) ? CMD_HIT : CMD_MOVE);
		r.key = ($urandom_range(99) < 80) ? hot_key[$urandom_range(HOT_KEYS - 1)] : KEY_W'($urandom);
		k     = int'(r.key);
		pick  = $urandom_range(99);
		if (pick < 45 && face_ok[k])
			r.face = prev_face[k];
		else if (pick < 60 && int_faces_shadow != 0)
			r.face = FACE_W'($urandom_range(int_faces_shadow - 1, 0));
		else if (pick < 75)
			r.face = FACE_W'($urandom);
		else
			r.face = FACE_W'($urandom_range(24'hFF_FFFF, int_faces_shadow));
		pick = $urandom_range(99);
		span = 64'(min_dist_shadow) + 1;
		if (pick < 10) begin
			r.px = prev_x[k];
			r.py = prev_y[k];
			r.pz = prev_z[k];
		end else if (pick < 55) begin
			r.px = POS_W'(longint'(prev_x[k]) + jitter(span));
			r.py = POS_W'(longint'(prev_y[k]) + jitter(span));
			r.pz = POS_W'(longint'(prev_z[k]) + jitter(span));
		end else if (pick < 80) begin
			r.px = POS_W'($urandom);
			r.py = POS_W'($urandom);
			r.pz = POS_W'($urandom);
		end else begin
			r.px = POS_W'(longint'($urandom_range(32'h01FF_FFFF)) - 64'h0100_0000);
			r.py = POS_W'(longint'($urandom_range(32'h01FF_FFFF)) - 64'h0100_0000);
			r.pz = POS_W'(longint'($urandom_range(32'h01FF_FFFF)) - 64'h0100_0000);
		end
		r.keep = ($urandom_range(99) < 85);
		return r;
	endfunction

	// Writes all three registers on consecutive edges.
	task automatic write_settings(logic [CNT_W-1:0] mh, logic [DIST_W-1:0] md, logic [FACE_W-1:0] inf);
		cfg_write <= 1'b1;
		cfg_index <= REG_MAX_HITS;
		cfg_data  <= DIST_W'(mh);
		@(posedge clk);
		cfg_index <= REG_MIN_DIST;
		cfg_data  <= md;
		@(posedge clk);
		cfg_index <= REG_INT_FACES;
		cfg_data  <= DIST_W'(inf);
		@(posedge clk);
		cfg_write <= 1'b0;
		max_hits_shadow  = mh;
		min_dist_shadow  = md;
		int_faces_shadow = inf;
	endtask

	// Presents one request, records its verdict and waits until it is accepted.
	task automatic offer(request_t r, logic typed, verdict_t want);
		verdict_t v;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		command      <= r.cmd;
		particle_key <= r.key;
		face_index   <= r.face;
		pos_x        <= r.px;
		pos_y        <= r.py;
		pos_z        <= r.pz;
		keep_in      <= r.keep;
		v = predict_verdict(r);
		verdicts_due.push_back(typed ? want : v);
		do
			@(posedge clk);
		while (in_ready !== 1'b1);
	endtask

	// Holds off the sender until every outstanding verdict has arrived.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (verdicts_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Result checker and receiver back-pressure.
	always @(posedge clk) begin
		verdict_t got;
		verdict_t want;
		got = '{keep_out, newly_eliminated, reason, eliminated_count};
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (verdicts_due.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("cycle %0d: unexpected result keep %0b newly %0b reason %0d count %0d",
						cycles, got.keep, got.newly, got.why, got.total);
			end else begin
				want = verdicts_due.pop_front();
				if (got.keep !== want.keep || got.newly !== want.newly ||
						got.why !== want.why || got.total !== want.total) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display({"cycle %0d: expected keep %0b newly %0b reason %0d count %0d, ",
							"got keep %0b newly %0b reason %0d count %0d"}, cycles,
							want.keep, want.newly, want.why, want.total,
							got.keep, got.newly, got.why, got.total);
				end
			end
		end
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("stuck_particle_eliminator_tb failed");
			$finish;
		end
	end

	// Stimulus sequence.
	initial begin
		verdict_t none;
		none = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		send_idle_pct = 15;
		recv_idle_pct = 82;
		write_settings(16'd2, 31'h0001_0000, 24'd16);

		// Directed table: history of a few particles under max_hits 2, 1.0 distance, 16 internal faces.
		directed_rows.push_back(stim_row(CMD_MOVE, 5, 0, 0, 0, 0, 1, 1, 1, 0, REASON_NONE, 0));
		directed_rows.push_back(stim_row(CMD_MOVE, 5, 0, 0, 0, 0, 0, 1, 0, 0, REASON_NONE, 0));
		// Internal face on an unknown particle changes nothing.
		directed_rows.push_back(stim_row(CMD_HIT, 5, 3, 0, 0, 0, 1, 1, 1, 0, REASON_NONE, 0));
		directed_rows.push_back(stim_row(CMD_HIT, 5, 100, 0, 0, 0, 1, 1, 1, 0, REASON_NONE, 0));
		directed_rows.push_back(stim_row(CMD_HIT, 5, 200, 32'h7FFF_FFFF, 32'h8000_0000, 0, 1,
			0, 0, 0, REASON_NONE, 0));
		directed_rows.push_back(stim_row(CMD_HIT, 5, 200, 32'h7FFF_FFFF, 32'h8000_0000, 0, 1,
			1, 0, 1, REASON_CLOSE, 1));
		// Over the run limit but no longer kept.
		directed_rows.push_back(stim_row(CMD_HIT, 5, 200, 0, 0, 0, 0, 0, 0, 0, REASON_NONE, 0));
		directed_rows.push_back(stim_row(CMD_MOVE, 5, 0, 0, 0, 0, 1, 1, 0, 0, REASON_NONE, 1));
		// Already in the eliminated set: reason given, not newly eliminated.
		directed_rows.push_back(stim_row(CMD_HIT, 5, 200, 32'h0100_0000, 0, 0, 1, 0, 0, 0, REASON_NONE, 0));
		directed_rows.push_back(stim_row(CMD_HIT, 7, 300, 0, 0, 0, 1, 0, 0, 0, REASON_NONE, 0));
		directed_rows.push_back(stim_row(CMD_HIT, 7, 300, 32'h0010_0000, 0, 0, 1, 0, 0, 0, REASON_NONE, 0));
		directed_rows.push_back(stim_row(CMD_HIT, 7, 300, 32'h0020_0000, 0, 0, 1, 0, 0, 0, REASON_NONE, 0));
		// Internal face on a known particle, then the same spot: no distance or face history left.
		directed_rows.push_back(stim_row(CMD_HIT, 7, 5, 0, 0, 0, 1, 0, 0, 0, REASON_NONE, 0));
		directed_rows.push_back(stim_row(CMD_HIT, 7, 300, 32'h0020_0000, 0, 0, 1, 0, 0, 0, REASON_NONE, 0));
		directed_rows.push_back(stim_row(CMD_HIT, 4095, 24'hFF_FFFF, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 1, 0, 0, 0, REASON_NONE, 0));
		directed_rows.push_back(stim_row(CMD_HIT, 4095, 24'hFF_FFFF, 32'h8000_8000, 32'h8000_0000,
			32'h8000_0000, 1, 0, 0, 0, REASON_NONE, 0));
		// Too close while not kept: no elimination.
		directed_rows.push_back(stim_row(CMD_HIT, 4095, 24'hFF_FFFF, 32'h8000_8000, 32'h8000_0000,
			32'h8000_0000, 0, 0, 0, 0, REASON_NONE, 0));
		// Face equal to the internal bound is a boundary face.
		directed_rows.push_back(stim_row(CMD_HIT, 0, 16, 0, 0, 0, 1, 0, 0, 0, REASON_NONE, 0));
		directed_rows.push_back(stim_row(CMD_HIT, 0, 15, 0, 0, 0, 1, 0, 0, 0, REASON_NONE, 0));
		directed_rows.push_back(stim_row(CMD_HIT, 0, 16, 0, 0, 0, 1, 0, 0, 0, REASON_NONE, 0));
		directed_rows.push_back(stim_row(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 1, 0, 0, REASON_NONE, 0));
		directed_rows.push_back(stim_row(CMD_CLEAR, 4095, 24'hFF_FFFF, -1, -1, -1, 1,
			1, 1, 0, REASON_NONE, 0));
		directed_rows.push_back(stim_row(CMD_MOVE, 5, 0, 0, 0, 0, 1, 1, 1, 0, REASON_NONE, 0));
		directed_rows.push_back(stim_row(CMD_HIT, 5, 200, 0, 0, 0, 1, 1, 1, 0, REASON_NONE, 0));
		foreach (directed_rows[i])
			offer(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
		drain();

		// Random phases over several settings, the extremes among them.
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: write_settings(16'd2, 31'h0001_0000, 24'h00_0100);
				1: write_settings(16'd0, 31'h0000_0000, 24'h00_0000);
				2: write_settings(16'hFFFF, 31'h7FFF_FFFF, 24'hFF_FFFF);
				3: write_settings(16'd1, 31'h0040_0000, 24'h00_1000);
				4: write_settings(16'd3, 31'h0000_0001, 24'h00_0010);
				default: write_settings(CNT_W'($urandom_range(8, 2)), DIST_W'($urandom_range(32'h0100_0000)),
					FACE_W'($urandom_range(16'hFFFF)));
			endcase
			send_idle_pct = (phase < 2) ? 15 : ((phase < 4) ? 82 : 0);
			recv_idle_pct = (phase < 2) ? 82 : ((phase < 4) ? 15 : 0);
			foreach (hot_key[i])
				hot_key[i] = KEY_W'($urandom);
			for (int n = 0; n < PHASE_REQUESTS; n++) begin
				offer(random_request(), 1'b0, none);
				if ($urandom_range(59) == 0)
					drain();
			end
			drain();
		end

		if (mismatches == 0)
			$display("stuck_particle_eliminator_tb passed");
		else
			$display("stuck_particle_eliminator_tb failed");
		$finish;
	end

endmodule
